>>> design/lsd_pkg.sv
package lsd_pkg;

	localparam int COORD_W = 20;
	localparam int VEC_W   = 3 * COORD_W;
	localparam int THR_W   = 25;
	localparam int DET_W   = 32;
	localparam int DIV_NW  = 52;
	localparam int S0_W    = 32;
	localparam int S1_W    = 21;

	localparam logic [THR_W-1:0] THR_RESET = 25'd168;

	typedef enum logic [1:0] {
		CASE_INTERIOR = 2'd0,
		CASE_END_POS  = 2'd1,
		CASE_END_NEG  = 2'd2,
		CASE_PARALLEL = 2'd3
	} case_t;

	// arithmetic shift right by s, rounding half toward +inf
	function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
		input int unsigned s);
		logic signed [63:0] half;
		half = 64'sd1 <<< (s - 1);
		return (v + half) >>> s;
	endfunction

endpackage

>>> design/lsd_div.sv
module lsd_div import lsd_pkg::*; #(
	parameter int NW = DIV_NW,
	parameter int DW = DET_W,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [DW-1:0] divisor,
	input  logic [NW-1:0] num0,
	input  logic [NW-1:0] num1,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [NW-1:0] quo0,
	output logic [NW-1:0] quo1,
	output logic [SW-1:0] side_out
);

	typedef struct packed {
		logic [DW-1:0] rem;
		logic [NW-1:0] wq;
	} dstep_t;

	// one restoring step: dividend bits leave the top of wq, quotient bits enter below
	function automatic dstep_t div_step(input dstep_t x, input logic [DW-1:0] d);
		logic [DW:0] t;
		dstep_t      y;
		t    = {x.rem, x.wq[NW-1]};
		y.wq = {x.wq[NW-2:0], 1'b0};
		if (t >= {1'b0, d}) begin
			t       = t - {1'b0, d};
			y.wq[0] = 1'b1;
		end
		y.rem = t[DW-1:0];
		return y;
	endfunction

	logic          vld_s [NW];
	dstep_t        a_s   [NW];
	dstep_t        b_s   [NW];
	logic [DW-1:0] dv_s  [NW];
	logic [SW-1:0] sd_s  [NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NW; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
			for (int k = 1; k < NW; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		a_s[0]  <= div_step(dstep_t'{rem: '0, wq: num0}, divisor);
		b_s[0]  <= div_step(dstep_t'{rem: '0, wq: num1}, divisor);
		dv_s[0] <= divisor;
		sd_s[0] <= side_in;
		for (int k = 1; k < NW; k++) begin
			a_s[k]  <= div_step(a_s[k-1], dv_s[k-1]);
			b_s[k]  <= div_step(b_s[k-1], dv_s[k-1]);
			dv_s[k] <= dv_s[k-1];
			sd_s[k] <= sd_s[k-1];
		end
	end

	assign out_vld  = vld_s[NW-1];
	assign quo0     = a_s[NW-1].wq;
	assign quo1     = b_s[NW-1].wq;
	assign side_out = sd_s[NW-1];

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld == $past(in_vld, NW))
		else $error("divider latency mismatch");

	a_rem0: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NW-1] && dv_s[NW-1] != '0) |-> a_s[NW-1].rem < dv_s[NW-1])
		else $error("remainder 0 not below divisor");

	a_rem1: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[NW-1] && dv_s[NW-1] != '0) |-> b_s[NW-1].rem < dv_s[NW-1])
		else $error("remainder 1 not below divisor");

endmodule

>>> design/line_segment_distance_3d.sv
// channel   | ports                                              | dir | transfer when
// ----------+----------------------------------------------------+-----+------------------
// query     | start, busy, line_*, segment_*                     | in  | start && !busy
// result    | done, squared_distance, *_parameter, point_*, case | out | done (one cycle)
// config    | cfg_we, cfg_wdata                                  | in  | cfg_we
//
// fully pipelined: one query per cycle while busy is low
// the divider is restoring, one quotient bit per stage
// busy is high only while reset is applied and for the first cycle after it
// the receiver cannot stall, so nothing holds the pipe; results leave in order
// write cfg only while no query is in flight
module line_segment_distance_3d import lsd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [VEC_W-1:0]        line_origin,
	input  logic [VEC_W-1:0]        line_direction,
	input  logic [VEC_W-1:0]        segment_center,
	input  logic [VEC_W-1:0]        segment_direction,
	input  logic [COORD_W-1:0]      segment_half_length,
	input  logic                    cfg_we,
	input  logic [THR_W-1:0]        cfg_wdata,
	output logic                    done,
	output logic [39:0]             squared_distance,
	output logic signed [23:0]      line_parameter,
	output logic signed [S1_W-1:0]  segment_parameter,
	output logic [VEC_W-1:0]        point_on_line,
	output logic [VEC_W-1:0]        point_on_segment,
	output logic [1:0]              closest_case
);

	localparam int LAT = 14 + DIV_NW;

	// unit of Q.36 used for det = |1 - a01^2|
	localparam logic signed [45:0] ONE36 = 46'sd1 <<< 36;
	localparam logic signed [53:0] S0_HI = 54'sd1 <<< 30;

	// everything the divider carries alongside the two quotients
	typedef struct packed {
		case_t                   cs;
		logic                    sgn0;
		logic                    sgn1;
		logic signed [S0_W-1:0]  s0e;
		logic signed [S1_W-1:0]  s1e;
		logic signed [22:0]      a01;
		logic signed [30:0]      b0;
		logic signed [30:0]      b1;
		logic signed [43:0]      c;
		logic [VEC_W-1:0]        lo;
		logic [VEC_W-1:0]        d0;
		logic [VEC_W-1:0]        sc;
		logic [VEC_W-1:0]        d1;
	} side_t;

	// pick one signed coordinate out of a packed vector
	function automatic logic signed [COORD_W-1:0] lane(input logic [VEC_W-1:0] v,
		input int i);
		return signed'(v[COORD_W*i +: COORD_W]);
	endfunction

	// base + round(prod / 2^18), saturated to one Q8.12 coordinate
	function automatic logic [COORD_W-1:0] pt_coord(input logic signed [COORD_W-1:0] base,
		input logic signed [51:0] prod);
		logic signed [63:0] p;
		p = 64'(base) + rnd_sh(64'(prod), 18);
		if (p > 64'sd524287) return COORD_W'(20'h7FFFF);
		if (p < -64'sd524288) return COORD_W'(20'h80000);
		return p[COORD_W-1:0];
	endfunction

	logic             busy_q;
	logic [THR_W-1:0] thr_q;
	logic             in_fire;

	assign in_fire = start && !busy_q;
	assign busy    = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			thr_q  <= THR_RESET;
		end else begin
			busy_q <= 1'b0;
			if (cfg_we) thr_q <= cfg_wdata;
		end
	end

	// valid chain
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11, vld_s12, vld_s13, vld_s14;
	logic div_vld;

	// stage 1: unpack, origin minus center
	logic signed [20:0]     diff_c [3];
	logic signed [20:0]     diff_s1 [3];
	logic [VEC_W-1:0]       lo_s1, d0_s1, sc_s1, d1_s1;
	logic [COORD_W-1:0]     ext_s1;

	// stage 2: the twelve coordinate products
	logic signed [39:0]     p01_s2 [3];
	logic signed [40:0]     pd0_s2 [3];
	logic signed [40:0]     pd1_s2 [3];
	logic signed [41:0]     pcc_s2 [3];
	logic [VEC_W-1:0]       lo_s2, d0_s2, sc_s2, d1_s2;
	logic [COORD_W-1:0]     ext_s2;

	// stage 3: dot products rounded to a01, b0, b1 and c
	logic signed [41:0]     dot_c;
	logic signed [42:0]     dd0_c, dd1_c;
	logic signed [22:0]     a01_s3;
	logic signed [30:0]     b0_s3, b1_s3;
	logic signed [43:0]     c_s3;
	logic [VEC_W-1:0]       lo_s3, d0_s3, sc_s3, d1_s3;
	logic [COORD_W-1:0]     ext_s3;

	// stage 4: a01^2 and the cross terms
	logic signed [45:0]     a2_s4;
	logic signed [53:0]     pab0_s4, pab1_s4;
	logic signed [22:0]     a01_s4;
	logic signed [30:0]     b0_s4, b1_s4;
	logic signed [43:0]     c_s4;
	logic [VEC_W-1:0]       lo_s4, d0_s4, sc_s4, d1_s4;
	logic [COORD_W-1:0]     ext_s4;

	// stage 5: det and both numerators
	logic [45:0]            det36_c, detr_c;
	logic [DET_W-1:0]       det_s5;
	logic signed [53:0]     n1_s5, num0_s5;
	logic signed [22:0]     a01_s5;
	logic signed [30:0]     b0_s5, b1_s5;
	logic signed [43:0]     c_s5;
	logic [VEC_W-1:0]       lo_s5, d0_s5, sc_s5, d1_s5;
	logic [COORD_W-1:0]     ext_s5;

	// stage 6: clamp window e*det and parallel test
	logic [51:0]            e_s6;
	logic                   par_s6;
	logic [DET_W-1:0]       det_s6;
	logic signed [53:0]     n1_s6, num0_s6;
	logic signed [22:0]     a01_s6;
	logic signed [30:0]     b0_s6, b1_s6;
	logic signed [43:0]     c_s6;
	logic [VEC_W-1:0]       lo_s6, d0_s6, sc_s6, d1_s6;
	logic [COORD_W-1:0]     ext_s6;

	// stage 7: classify, set up divider operands
	logic signed [53:0]     es_c, abs0_c, abs1_c;
	case_t                  cs_c;
	logic signed [S1_W-1:0] s1e_c, extv_c;
	case_t                  cs_s7;
	logic signed [S1_W-1:0] s1e_s7;
	logic [DIV_NW-1:0]      mag0_s7, mag1_s7;
	logic                   sgn0_s7, sgn1_s7;
	logic [DET_W-1:0]       det_s7;
	logic signed [22:0]     a01_s7;
	logic signed [30:0]     b0_s7, b1_s7;
	logic signed [43:0]     c_s7;
	logic [VEC_W-1:0]       lo_s7, d0_s7, sc_s7, d1_s7;

	// stage 8: a01 * s1 for the end cases
	logic signed [43:0]     pas_s8;
	case_t                  cs_s8;
	logic signed [S1_W-1:0] s1e_s8;
	logic [DIV_NW-1:0]      mag0_s8, mag1_s8;
	logic                   sgn0_s8, sgn1_s8;
	logic [DET_W-1:0]       det_s8;
	logic signed [22:0]     a01_s8;
	logic signed [30:0]     b0_s8, b1_s8;
	logic signed [43:0]     c_s8;
	logic [VEC_W-1:0]       lo_s8, d0_s8, sc_s8, d1_s8;

	// stage 9: s0 for end and parallel cases, divider input
	logic signed [S0_W-1:0] s0e_c;
	side_t                  side_s9;
	logic [DIV_NW-1:0]      mag0_s9, mag1_s9;
	logic [DET_W-1:0]       det_s9;

	// divider output
	logic [DIV_NW-1:0]      quo0, quo1;
	logic [$bits(side_t)-1:0] side_bits;
	side_t                  sd;

	// stage 10: final s0, s1
	logic signed [53:0]     s0raw_c;
	logic signed [S0_W-1:0] s0_c;
	logic signed [S1_W-1:0] s1_c;
	logic signed [S0_W-1:0] s0_s10;
	logic signed [S1_W-1:0] s1_s10;
	case_t                  cs_s10;
	logic signed [22:0]     a01_s10;
	logic signed [30:0]     b0_s10, b1_s10;
	logic signed [43:0]     c_s10;
	logic [VEC_W-1:0]       lo_s10, d0_s10, sc_s10, d1_s10;

	// stage 11: quadratic terms and point products
	logic signed [24:0]     bq0_c, bq1_c;
	logic signed [63:0]     sq0_s11;
	logic signed [41:0]     sq1_s11;
	logic signed [43:0]     as1_s11;
	logic signed [56:0]     bb0_s11;
	logic signed [45:0]     bb1_s11;
	logic signed [51:0]     pl_s11 [3];
	logic signed [51:0]     ps_s11 [3];
	logic signed [S0_W-1:0] s0_s11;
	logic signed [S1_W-1:0] s1_s11;
	case_t                  cs_s11;
	logic signed [43:0]     c_s11;
	logic [VEC_W-1:0]       lo_s11, sc_s11;

	// stage 12: rounded A, partial sum, points
	logic signed [25:0]     am_s12;
	logic signed [63:0]     part_s12;
	logic [VEC_W-1:0]       pol_s12, pos_s12;
	logic signed [S0_W-1:0] s0_s12;
	logic signed [S1_W-1:0] s1_s12;
	case_t                  cs_s12;

	// stage 13: A * s0
	logic signed [57:0]     ap_s13;
	logic signed [63:0]     part_s13;
	logic [VEC_W-1:0]       pol_s13, pos_s13;
	logic signed [S0_W-1:0] s0_s13;
	logic signed [S1_W-1:0] s1_s13;
	case_t                  cs_s13;

	// stage 14: outputs
	logic signed [63:0]     q_c;
	logic [39:0]            dist_s14;
	logic signed [23:0]     lp_s14;
	logic signed [S1_W-1:0] s1_s14;
	logic [VEC_W-1:0]       pol_s14, pos_s14;
	case_t                  cs_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
		end else begin
			vld_s1  <= in_fire;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= div_vld;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
		end
	end

	// combinational pieces between stages
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff_c[i] = 21'(lane(line_origin, i)) - 21'(lane(segment_center, i));
		end

		dot_c = 42'(p01_s2[0]) + 42'(p01_s2[1]) + 42'(p01_s2[2]);
		dd0_c = 43'(pd0_s2[0]) + 43'(pd0_s2[1]) + 43'(pd0_s2[2]);
		dd1_c = 43'(pd1_s2[0]) + 43'(pd1_s2[1]) + 43'(pd1_s2[2]);

		// det = round(|2^36 - a01^2| / 2^12)
		if (a2_s4 > ONE36) det36_c = 46'(a2_s4 - ONE36);
		else det36_c = 46'(ONE36 - a2_s4);
		detr_c = det36_c + 46'd2048;

		// case decision against the window [-e, e]
		es_c   = $signed({2'b00, e_s6});
		extv_c = $signed({1'b0, ext_s6});
		if (par_s6) begin
			cs_c  = CASE_PARALLEL;
			s1e_c = '0;
		end else if (n1_s6 > es_c) begin
			cs_c  = CASE_END_POS;
			s1e_c = extv_c;
		end else if (n1_s6 < -es_c) begin
			cs_c  = CASE_END_NEG;
			s1e_c = -extv_c;
		end else begin
			cs_c  = CASE_INTERIOR;
			s1e_c = '0;
		end
		abs0_c = num0_s6[53] ? -num0_s6 : num0_s6;
		abs1_c = n1_s6[53] ? -n1_s6 : n1_s6;

		// s0 outside the interior
		if (cs_s8 == CASE_PARALLEL) begin
			s0e_c = S0_W'(rnd_sh(-64'(b0_s8), 6));
		end else begin
			s0e_c = S0_W'(rnd_sh(-(64'(pas_s8) + (64'(b0_s8) <<< 12)), 18));
		end

		// quotients get their sign back, s0 is bounded to +-2^30
		if (sd.cs == CASE_INTERIOR) begin
			s0raw_c = sd.sgn0 ? -$signed({2'b00, quo0}) : $signed({2'b00, quo0});
			s1_c    = sd.sgn1 ? -$signed(quo1[S1_W-1:0]) : $signed(quo1[S1_W-1:0]);
		end else begin
			s0raw_c = 54'(sd.s0e);
			s1_c    = sd.s1e;
		end
		if (s0raw_c > S0_HI) s0_c = S0_W'(S0_HI);
		else if (s0raw_c < -S0_HI) s0_c = S0_W'(-S0_HI);
		else s0_c = S0_W'(s0raw_c);

		bq0_c = 25'(rnd_sh(64'(b0_s10), 6));
		bq1_c = 25'(rnd_sh(64'(b1_s10), 6));

		// distance, clamped to the unsigned Q16.24 range
		q_c = part_s13 + (64'(ap_s13) <<< 1);
	end

	assign sd = side_bits;

	always_ff @(posedge clk) begin
		// stage 1
		for (int i = 0; i < 3; i++) diff_s1[i] <= diff_c[i];
		lo_s1  <= line_origin;
		d0_s1  <= line_direction;
		sc_s1  <= segment_center;
		d1_s1  <= segment_direction;
		ext_s1 <= segment_half_length;

		// stage 2
		for (int i = 0; i < 3; i++) begin
			p01_s2[i] <= lane(d0_s1, i) * lane(d1_s1, i);
			pd0_s2[i] <= diff_s1[i] * lane(d0_s1, i);
			pd1_s2[i] <= diff_s1[i] * lane(d1_s1, i);
			pcc_s2[i] <= diff_s1[i] * diff_s1[i];
		end
		lo_s2  <= lo_s1;
		d0_s2  <= d0_s1;
		sc_s2  <= sc_s1;
		d1_s2  <= d1_s1;
		ext_s2 <= ext_s1;

		// stage 3
		a01_s3 <= 23'(rnd_sh(-64'(dot_c), 18));
		b0_s3  <= 31'(rnd_sh(64'(dd0_c), 12));
		b1_s3  <= 31'(rnd_sh(-64'(dd1_c), 12));
		c_s3   <= 44'(pcc_s2[0]) + 44'(pcc_s2[1]) + 44'(pcc_s2[2]);
		lo_s3  <= lo_s2;
		d0_s3  <= d0_s2;
		sc_s3  <= sc_s2;
		d1_s3  <= d1_s2;
		ext_s3 <= ext_s2;

		// stage 4
		a2_s4   <= a01_s3 * a01_s3;
		pab0_s4 <= a01_s3 * b0_s3;
		pab1_s4 <= a01_s3 * b1_s3;
		a01_s4  <= a01_s3;
		b0_s4   <= b0_s3;
		b1_s4   <= b1_s3;
		c_s4    <= c_s3;
		lo_s4   <= lo_s3;
		d0_s4   <= d0_s3;
		sc_s4   <= sc_s3;
		d1_s4   <= d1_s3;
		ext_s4  <= ext_s3;

		// stage 5
		det_s5  <= detr_c[43:12];
		n1_s5   <= pab0_s4 - (54'(b1_s4) <<< 18);
		num0_s5 <= pab1_s4 - (54'(b0_s4) <<< 18);
		a01_s5  <= a01_s4;
		b0_s5   <= b0_s4;
		b1_s5   <= b1_s4;
		c_s5    <= c_s4;
		lo_s5   <= lo_s4;
		d0_s5   <= d0_s4;
		sc_s5   <= sc_s4;
		d1_s5   <= d1_s4;
		ext_s5  <= ext_s4;

		// stage 6
		e_s6    <= ext_s5 * det_s5;
		par_s6  <= (det_s5 == '0) || (det_s5 < DET_W'(thr_q));
		det_s6  <= det_s5;
		n1_s6   <= n1_s5;
		num0_s6 <= num0_s5;
		a01_s6  <= a01_s5;
		b0_s6   <= b0_s5;
		b1_s6   <= b1_s5;
		c_s6    <= c_s5;
		lo_s6   <= lo_s5;
		d0_s6   <= d0_s5;
		sc_s6   <= sc_s5;
		d1_s6   <= d1_s5;
		ext_s6  <= ext_s5;

		// stage 7: round-to-nearest division is (|n| + det/2) / det
		cs_s7   <= cs_c;
		s1e_s7  <= s1e_c;
		mag0_s7 <= DIV_NW'(abs0_c) + DIV_NW'(det_s6 >> 1);
		mag1_s7 <= DIV_NW'(abs1_c) + DIV_NW'(det_s6 >> 1);
		sgn0_s7 <= num0_s6[53];
		sgn1_s7 <= n1_s6[53];
		det_s7  <= det_s6;
		a01_s7  <= a01_s6;
		b0_s7   <= b0_s6;
		b1_s7   <= b1_s6;
		c_s7    <= c_s6;
		lo_s7   <= lo_s6;
		d0_s7   <= d0_s6;
		sc_s7   <= sc_s6;
		d1_s7   <= d1_s6;

		// stage 8
		pas_s8  <= a01_s7 * s1e_s7;
		cs_s8   <= cs_s7;
		s1e_s8  <= s1e_s7;
		mag0_s8 <= mag0_s7;
		mag1_s8 <= mag1_s7;
		sgn0_s8 <= sgn0_s7;
		sgn1_s8 <= sgn1_s7;
		det_s8  <= det_s7;
		a01_s8  <= a01_s7;
		b0_s8   <= b0_s7;
		b1_s8   <= b1_s7;
		c_s8    <= c_s7;
		lo_s8   <= lo_s7;
		d0_s8   <= d0_s7;
		sc_s8   <= sc_s7;
		d1_s8   <= d1_s7;

		// stage 9
		side_s9.cs   <= cs_s8;
		side_s9.sgn0 <= sgn0_s8;
		side_s9.sgn1 <= sgn1_s8;
		side_s9.s0e  <= s0e_c;
		side_s9.s1e  <= s1e_s8;
		side_s9.a01  <= a01_s8;
		side_s9.b0   <= b0_s8;
		side_s9.b1   <= b1_s8;
		side_s9.c    <= c_s8;
		side_s9.lo   <= lo_s8;
		side_s9.d0   <= d0_s8;
		side_s9.sc   <= sc_s8;
		side_s9.d1   <= d1_s8;
		mag0_s9      <= mag0_s8;
		mag1_s9      <= mag1_s8;
		det_s9       <= det_s8;

		// stage 10
		s0_s10  <= s0_c;
		s1_s10  <= s1_c;
		cs_s10  <= sd.cs;
		a01_s10 <= sd.a01;
		b0_s10  <= sd.b0;
		b1_s10  <= sd.b1;
		c_s10   <= sd.c;
		lo_s10  <= sd.lo;
		d0_s10  <= sd.d0;
		sc_s10  <= sd.sc;
		d1_s10  <= sd.d1;

		// stage 11
		sq0_s11 <= s0_s10 * s0_s10;
		sq1_s11 <= s1_s10 * s1_s10;
		as1_s11 <= a01_s10 * s1_s10;
		bb0_s11 <= bq0_c * s0_s10;
		bb1_s11 <= bq1_c * s1_s10;
		for (int i = 0; i < 3; i++) begin
			pl_s11[i] <= lane(d0_s10, i) * s0_s10;
			ps_s11[i] <= lane(d1_s10, i) * s1_s10;
		end
		s0_s11  <= s0_s10;
		s1_s11  <= s1_s10;
		cs_s11  <= cs_s10;
		c_s11   <= c_s10;
		lo_s11  <= lo_s10;
		sc_s11  <= sc_s10;

		// stage 12
		am_s12   <= 26'(rnd_sh(64'(as1_s11), 18));
		part_s12 <= sq0_s11 + 64'(sq1_s11) + (64'(bb0_s11) <<< 1)
			+ (64'(bb1_s11) <<< 1) + 64'(c_s11);
		for (int i = 0; i < 3; i++) begin
			pol_s12[COORD_W*i +: COORD_W] <= pt_coord(lane(lo_s11, i), pl_s11[i]);
			pos_s12[COORD_W*i +: COORD_W] <= pt_coord(lane(sc_s11, i), ps_s11[i]);
		end
		s0_s12   <= s0_s11;
		s1_s12   <= s1_s11;
		cs_s12   <= cs_s11;

		// stage 13
		ap_s13   <= am_s12 * s0_s12;
		part_s13 <= part_s12;
		pol_s13  <= pol_s12;
		pos_s13  <= pos_s12;
		s0_s13   <= s0_s12;
		s1_s13   <= s1_s12;
		cs_s13   <= cs_s12;

		// stage 14
		if (q_c < 64'sd0) dist_s14 <= '0;
		else if (q_c > 64'sh00FF_FFFF_FFFF) dist_s14 <= '1;
		else dist_s14 <= q_c[39:0];
		if (s0_s13 > 32'sd8388607) lp_s14 <= 24'sh7FFFFF;
		else if (s0_s13 < -32'sd8388608) lp_s14 <= 24'sh800000;
		else lp_s14 <= s0_s13[23:0];
		s1_s14  <= s1_s13;
		pol_s14 <= pol_s13;
		pos_s14 <= pos_s13;
		cs_s14  <= cs_s13;
	end

	// both quotients share one divisor, one bit per stage
	lsd_div #(
		.NW (DIV_NW),
		.DW (DET_W),
		.SW ($bits(side_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s9),
		.divisor  (det_s9),
		.num0     (mag0_s9),
		.num1     (mag1_s9),
		.side_in  (side_s9),
		.out_vld  (div_vld),
		.quo0     (quo0),
		.quo1     (quo1),
		.side_out (side_bits)
	);

	assign done              = vld_s14;
	assign squared_distance  = dist_s14;
	assign line_parameter    = lp_s14;
	assign segment_parameter = s1_s14;
	assign point_on_line     = pol_s14;
	assign point_on_segment  = pos_s14;
	assign closest_case      = cs_s14;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(start && !busy, LAT))
		else $error("result strobe not at fixed latency");

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose outside reset");

	a_end_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && closest_case == CASE_END_POS) |-> !segment_parameter[S1_W-1])
		else $error("positive end with negative segment parameter");

	a_end_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(done && closest_case == CASE_END_NEG)
			|-> (segment_parameter[S1_W-1] || segment_parameter == '0))
		else $error("negative end with positive segment parameter");

endmodule

>>> dv/testbench.sv
module testbench import lsd_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	// one query: two vectors for the line, two for the segment, plus the extent
	typedef struct {
		logic [VEC_W-1:0]   org;
		logic [VEC_W-1:0]   ldir;
		logic [VEC_W-1:0]   ctr;
		logic [VEC_W-1:0]   sdir;
		logic [COORD_W-1:0] half;
	} query_t;

	typedef struct {
		logic [39:0]      sqd;
		logic [23:0]      lpar;
		logic [S1_W-1:0]  spar;
		logic [VEC_W-1:0] pl;
		logic [VEC_W-1:0] ps;
		case_t            kind;
	} approach_t;

	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN       = 80;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [VEC_W-1:0]       line_origin = '0;
	logic [VEC_W-1:0]       line_direction = '0;
	logic [VEC_W-1:0]       segment_center = '0;
	logic [VEC_W-1:0]       segment_direction = '0;
	logic [COORD_W-1:0]     segment_half_length = '0;
	logic                   cfg_we = 1'b0;
	logic [THR_W-1:0]       cfg_wdata = '0;
	logic                   done;
	logic [39:0]            squared_distance;
	logic signed [23:0]     line_parameter;
	logic signed [S1_W-1:0] segment_parameter;
	logic [VEC_W-1:0]       point_on_line;
	logic [VEC_W-1:0]       point_on_segment;
	logic [1:0]             closest_case;

	query_t    pending_queries[$];
	approach_t expected_results[$];
	logic [THR_W-1:0] parallel_bound = THR_RESET;
	bit  took = 1'b0;       // query transfer at the last rising edge
	bit  calm = 1'b0;       // no sender gaps while set
	bit  failed = 1'b0;
	int  stall_cycles = 0;

	line_segment_distance_3d u_top (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.line_origin         (line_origin),
		.line_direction      (line_direction),
		.segment_center      (segment_center),
		.segment_direction   (segment_direction),
		.segment_half_length (segment_half_length),
		.cfg_we              (cfg_we),
		.cfg_wdata           (cfg_wdata),
		.done                (done),
		.squared_distance    (squared_distance),
		.line_parameter      (line_parameter),
		.segment_parameter   (segment_parameter),
		.point_on_line       (point_on_line),
		.point_on_segment    (point_on_segment),
		.closest_case        (closest_case)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ---------------- arithmetic helpers for the predictor ----------------

	function automatic longint coord(input logic [VEC_W-1:0] v, input int i);
		logic [COORD_W-1:0] c;
		c = v[i*COORD_W +: COORD_W];
		return longint'(signed'({{(64-COORD_W){c[COORD_W-1]}}, c}));
	endfunction

	// floor((v + half) / 2^s): shift with rounding half up
	function automatic longint round_down_shift(input longint v, input int s);
		longint half;
		half = longint'(1) <<< (s - 1);
		return (v + half) >>> s;
	endfunction

	// nearest, ties away from zero, positive divisor
	function automatic longint div_nearest(input longint n, input longint d);
		longint unsigned mag;
		longint unsigned q;
		mag = n < 0 ? longint'(0) - n : n;
		q = (mag + longint'(d) / 2) / longint'(d);
		return n < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [VEC_W-1:0] walk(input logic [VEC_W-1:0] base,
		input logic [VEC_W-1:0] dir, input longint s);
		logic [VEC_W-1:0] r;
		longint p;
		r = '0;
		for (int i = 0; i < 3; i++) begin
			p = coord(base, i) + round_down_shift(coord(dir, i) * s, 18);
			p = clamp(p, -(longint'(1) << 19), (longint'(1) << 19) - 1);
			r[i*COORD_W +: COORD_W] = p[COORD_W-1:0];
		end
		return r;
	endfunction

	// closest approach of line and segment, fixed point as the block computes it
	function automatic approach_t closest_approach(input query_t q,
		input logic [THR_W-1:0] bound);
		approach_t r;
		longint diff[3];
		longint dot01, dd0, dd1, c, a01, b0, b1, s0, s1, det, n1, e, qd, ext, lp;
		longint unsigned a2, det36, one;
		case_t kind;
		dot01 = 0; dd0 = 0; dd1 = 0; c = 0;
		one = longint'(1) << 36;
		ext = longint'(q.half);
		for (int i = 0; i < 3; i++) begin
			diff[i] = coord(q.org, i) - coord(q.ctr, i);
			dot01 += coord(q.ldir, i) * coord(q.sdir, i);
			dd0 += diff[i] * coord(q.ldir, i);
			dd1 += diff[i] * coord(q.sdir, i);
			c += diff[i] * diff[i];
		end
		a01 = round_down_shift(-dot01, 18);
		b0 = round_down_shift(dd0, 12);
		b1 = round_down_shift(-dd1, 12);
		a2 = a01 * a01;
		det36 = a2 > one ? a2 - one : one - a2;
		det = longint'((det36 + 2048) >> 12);
		// zero det is parallel whatever the bound
		if (det != 0 && longint'(det) >= longint'(bound)) begin
			n1 = a01 * b0 - b1 * 262144;
			e = ext * det;
			if (n1 >= -e && n1 <= e) begin
				s0 = div_nearest(a01 * b1 - b0 * 262144, det);
				s1 = div_nearest(n1, det);
				kind = CASE_INTERIOR;
			end else begin
				s1 = n1 > e ? ext : -ext;
				kind = n1 > e ? CASE_END_POS : CASE_END_NEG;
				s0 = round_down_shift(-(a01 * s1 + b0 * 4096), 18);
			end
		end else begin
			s1 = 0;
			s0 = round_down_shift(-b0, 6);
			kind = CASE_PARALLEL;
		end
		s0 = clamp(s0, -(longint'(1) << 30), longint'(1) << 30);
		qd = s0 * s0 + 2 * round_down_shift(a01 * s1, 18) * s0 + s1 * s1
			+ 2 * round_down_shift(b0, 6) * s0 + 2 * round_down_shift(b1, 6) * s1 + c;
		qd = clamp(qd, 0, (longint'(1) << 40) - 1);
		lp = clamp(s0, -(longint'(1) << 23), (longint'(1) << 23) - 1);
		r.sqd = qd[39:0];
		r.lpar = lp[23:0];
		r.spar = s1[S1_W-1:0];
		r.pl = walk(q.org, q.ldir, s0);
		r.ps = walk(q.ctr, q.sdir, s1);
		r.kind = kind;
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic logic [COORD_W-1:0] rand_coord(input int bits);
		longint v;
		v = longint'($urandom_range(0, (1 << bits) - 1)) - (longint'(1) << (bits - 1));
		return v[COORD_W-1:0];
	endfunction

	function automatic logic [VEC_W-1:0] rand_position();
		int bits;
		logic [VEC_W-1:0] v;
		bits = 8 + 4 * $urandom_range(0, 3);
		for (int i = 0; i < 3; i++) v[i*COORD_W +: COORD_W] = rand_coord(bits);
		return v;
	endfunction

	function automatic logic [VEC_W-1:0] unit_vector(input real x, input real y,
		input real z);
		real n;
		real comp[3];
		longint k;
		logic [VEC_W-1:0] v;
		n = $sqrt(x * x + y * y + z * z);
		if (n == 0.0) begin
			x = 1.0; n = 1.0;
		end
		comp[0] = x / n; comp[1] = y / n; comp[2] = z / n;
		for (int i = 0; i < 3; i++) begin
			k = $rtoi(comp[i] * 262144.0);
			v[i*COORD_W +: COORD_W] = k[COORD_W-1:0];
		end
		return v;
	endfunction

	function automatic logic [VEC_W-1:0] rand_unit();
		return unit_vector(real'($urandom_range(0, 2000)) - 1000.0,
			real'($urandom_range(0, 2000)) - 1000.0,
			real'($urandom_range(0, 2000)) - 1000.0);
	endfunction

	function automatic query_t rand_query();
		query_t q;
		logic [COORD_W-1:0] c;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			// raw noise, every bit free
			q.org = VEC_W'({$urandom, $urandom}); q.ldir = VEC_W'({$urandom, $urandom});
			q.ctr = VEC_W'({$urandom, $urandom}); q.sdir = VEC_W'({$urandom, $urandom});
			q.half = COORD_W'($urandom);
			return q;
		end
		q.org = rand_position();
		q.ctr = rand_position();
		q.ldir = rand_unit();
		q.half = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(0, 1 << 14));
		if (pick < 35) begin
			// ldir with the sign of each coordinate picked at random, nudged in one coordinate
			q.sdir = $urandom_range(0, 1) ? q.ldir : VEC_W'(0) - q.ldir;
			for (int i = 0; i < 3; i++) begin
				c = $urandom_range(0, 1) ? q.ldir[i*COORD_W +: COORD_W]
					: COORD_W'(0) - q.ldir[i*COORD_W +: COORD_W];
				q.sdir[i*COORD_W +: COORD_W] = c;
			end
			c = q.sdir[COORD_W-1:0] + COORD_W'($urandom_range(0, 128)) - COORD_W'(64);
			q.sdir[COORD_W-1:0] = c;
		end else begin
			q.sdir = rand_unit();
		end
		return q;
	endfunction

	function automatic query_t make_query(input logic [VEC_W-1:0] org,
		input logic [VEC_W-1:0] ldir, input logic [VEC_W-1:0] ctr,
		input logic [VEC_W-1:0] sdir, input logic [COORD_W-1:0] half);
		query_t q;
		q.org = org; q.ldir = ldir; q.ctr = ctr; q.sdir = sdir; q.half = half;
		return q;
	endfunction

	// wait for the pipe to empty, then some slack
	task automatic wait_idle();
		while (pending_queries.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_bound(input logic [THR_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		parallel_bound = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ---------------- driver ----------------

	// inputs move on the falling edge; a held start stays high with no toggle
	always @(negedge clk) begin
		query_t q;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || took) begin
			if (pending_queries.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
				q = pending_queries.pop_front();
				line_origin <= q.org;
				line_direction <= q.ldir;
				segment_center <= q.ctr;
				segment_direction <= q.sdir;
				segment_half_length <= q.half;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------- monitor, predictor and watchdog ----------------

	always @(posedge clk) begin
		approach_t want;
		took = start && !busy && arst_n;
		if (took)
			expected_results.push_back(closest_approach(make_query(line_origin,
				line_direction, segment_center, segment_direction, segment_half_length),
				parallel_bound));
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no query outstanding");
				failed = 1'b1;
			end else begin
				want = expected_results.pop_front();
				if (squared_distance !== want.sqd) begin
					$error("squared_distance exp %h got %h", want.sqd, squared_distance);
					failed = 1'b1;
				end
				if (line_parameter !== want.lpar) begin
					$error("line_parameter exp %h got %h", want.lpar, line_parameter);
					failed = 1'b1;
				end
				if (segment_parameter !== want.spar) begin
					$error("segment_parameter exp %h got %h", want.spar, segment_parameter);
					failed = 1'b1;
				end
				if (point_on_line !== want.pl) begin
					$error("point_on_line exp %h got %h", want.pl, point_on_line);
					failed = 1'b1;
				end
				if (point_on_segment !== want.ps) begin
					$error("point_on_segment exp %h got %h", want.ps, point_on_segment);
					failed = 1'b1;
				end
				if (closest_case !== want.kind) begin
					$error("closest_case exp %0d got %0d", want.kind, closest_case);
					failed = 1'b1;
				end
			end
		end
		// watchdog on cycles with no transfer at all
		if (took || done) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("line_segment_distance_3d verification failed");
			$finish;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		logic [VEC_W-1:0] ex, ey, ez, big;
		logic [THR_W-1:0] bounds[5];
		ex = unit_vector(1.0, 0.0, 0.0);
		ey = unit_vector(0.0, 1.0, 0.0);
		ez = unit_vector(0.0, 0.0, 1.0);
		big = {3{20'h7FFFF}};
		bounds[0] = '0;
		bounds[1] = 25'h1FFFFFF;
		bounds[2] = 25'd16777216;
		bounds[3] = THR_RESET;
		bounds[4] = 25'($urandom_range(0, 1 << 20));

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, each case code, degenerate inputs
		pending_queries.push_back(make_query('0, '0, '0, '0, '0));
		pending_queries.push_back(make_query('1, '1, '1, '1, '1));
		pending_queries.push_back(make_query(big, big, ~big, ~big, 20'hFFFFF));
		pending_queries.push_back(make_query({3{20'h80000}}, ex, big, ey, 20'h7FFFF));
		// crossing perpendicular: interior
		pending_queries.push_back(make_query('0, ex, {20'h01000, 40'h0}, ey, 20'h04000));
		// segment offset along its own axis: positive end, negative end
		pending_queries.push_back(make_query('0, ex, {20'h0, 20'hF8000, 20'h0}, ey, 20'h01000));
		pending_queries.push_back(make_query('0, ex, {20'h0, 20'h08000, 20'h0}, ey, 20'h01000));
		// exactly parallel and anti-parallel, det zero
		pending_queries.push_back(make_query({20'h0, 20'h02000, 20'h0}, ez, '0, ez, 20'h02000));
		pending_queries.push_back(make_query(big, ez, '0, VEC_W'(0) - ez, 20'h02000));
		// zero length segment, huge line parameter
		pending_queries.push_back(make_query({3{20'h7FFFF}}, ex, {3{20'h80000}}, ey, '0));
		// non-unit directions
		pending_queries.push_back(make_query(big, {3{20'h7FFFF}}, '0, {3{20'h80000}}, 20'h00100));
		pending_queries.push_back(make_query('0, {3{20'h00001}}, big, ey, 20'h10000));
		for (int i = 0; i < 6; i++) pending_queries.push_back(rand_query());

		// phases over the threshold; waiting for the drain is the forced pause
		for (int p = 0; p < 5; p++) begin
			wait_idle();
			write_bound(bounds[p]);
			if (p == 2) begin
				// zero det under this phase's bound of 2^24, parallel
				pending_queries.push_back(make_query(big, ex, '0, ex, 20'h00800));
				pending_queries.push_back(make_query('0, ey, big, VEC_W'(0) - ey, 20'h00800));
			end
			calm = (p == 3);
			for (int i = 0; i < 355; i++) pending_queries.push_back(rand_query());
		end

		wait_idle();
		repeat (DRAIN) @(posedge clk);
		if (!failed)
			$display("line_segment_distance_3d verification clean");
		else
			$display("line_segment_distance_3d verification failed");
		$finish;
	end

endmodule

>>> files.f
design/lsd_pkg.sv
design/lsd_div.sv
design/line_segment_distance_3d.sv
dv/testbench.sv
